@@ rtl/core/sliding_window_rank_select_top_assert.svh @@
// Assertion macros for the sliding window rank select block.
`ifndef SLIDING_WINDOW_RANK_SELECT_TOP_ASSERT_SVH
`define SLIDING_WINDOW_RANK_SELECT_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SWRS_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sliding window rank select: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define SWRS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sliding window rank select: next-cycle check failed");

`endif

@@ rtl/core/swrs_pkg.sv @@
package swrs_pkg;

  localparam int SAMPLE_W     = 7;
  localparam int CFG_W        = 9;
  localparam int CFG_IDX_W    = 1;
  localparam int NUM_BINS     = 128;
  localparam int VALUE_OFFSET = 64;
  localparam int MAX_WINDOW   = 256;

  localparam int BIN_W      = $clog2(NUM_BINS);
  localparam int LIDX_W     = (BIN_W > 1) ? $clog2(BIN_W) : 1;
  localparam int PTR_W      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
  localparam int SAMPLE_MIN = -(2 ** (SAMPLE_W - 1));

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [CFG_W-1:0]           cfg_t;
  typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;
  typedef logic [BIN_W-1:0]           bin_t;
  typedef logic [LIDX_W-1:0]          lidx_t;
  typedef logic [PTR_W-1:0]           ptr_t;
  typedef logic [CNT_W-1:0]           cnt_t;

  // register indexes
  localparam cfg_idx_t REG_WINDOW_LENGTH = cfg_idx_t'(0);
  localparam cfg_idx_t REG_RANK          = cfg_idx_t'(1);

  localparam cfg_t  CFG_RESET = cfg_t'(1);
  localparam lidx_t LAST_LVL  = lidx_t'(BIN_W - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INC,
    S_PRIME,
    S_DESC,
    S_RESULT,
    S_DEC
  } state_t;

  // which bin drives the count tree address
  typedef enum logic [1:0] {
    SEL_LIVE,
    SEL_NEW,
    SEL_OLD,
    SEL_PATH
  } sel_t;

  typedef struct packed {
    logic  accept;
    logic  ring_rd;
    logic  inc_wr;
    logic  desc_init;
    logic  desc_step;
    logic  load_out;
    logic  dec_wr;
    sel_t  sel;
    lidx_t lvl;
  } cmd_t;

  typedef struct packed {
    logic emit;
    logic hit;
    logic out_busy;
  } stat_t;

  function automatic bin_t bin_of(sample_t s);
    int b;
    b = int'(s) + VALUE_OFFSET;
    if (b < 0) begin
      b = 0;
    end else if (b > NUM_BINS - 1) begin
      b = NUM_BINS - 1;
    end
    return bin_t'(b);
  endfunction

  function automatic sample_t beauty_of(bin_t i);
    int v;
    v = int'(i) - VALUE_OFFSET;
    if (v >= 0) begin
      v = 0;
    end else if (v < SAMPLE_MIN) begin
      v = SAMPLE_MIN;
    end
    return sample_t'(v);
  endfunction

endpackage

@@ rtl/core/swrs_ctrl.sv @@
module swrs_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  swrs_pkg::stat_t stat,
  output swrs_pkg::cmd_t  cmd
);
  import swrs_pkg::*;

  state_t state, state_next;
  lidx_t  lvl, lvl_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      lvl   <= '0;
    end else begin
      state <= state_next;
      lvl   <= lvl_next;
    end
  end

  always_comb begin
    state_next = state;
    lvl_next   = lvl;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_INC;
      end
      S_INC: begin
        if (!stat.emit) begin
          state_next = S_IDLE;
        end else if (stat.hit) begin
          state_next = S_PRIME;
        end else begin
          state_next = S_RESULT;
        end
      end
      S_PRIME: begin
        state_next = S_DESC;
        lvl_next   = '0;
      end
      S_DESC: begin
        if (lvl == LAST_LVL) begin
          state_next = S_RESULT;
        end else begin
          lvl_next = lvl + lidx_t'(1);
        end
      end
      S_RESULT: begin
        if (!stat.out_busy) state_next = S_DEC;
      end
      S_DEC: begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.sel  = SEL_LIVE;
    cmd.lvl  = lvl;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      S_INC: begin
        cmd.sel       = SEL_NEW;
        cmd.inc_wr    = 1'b1;
        cmd.ring_rd   = 1'b1;
        cmd.desc_init = 1'b1;
      end
      S_PRIME: begin
        cmd.sel = SEL_PATH;
      end
      S_DESC: begin
        cmd.sel       = SEL_PATH;
        cmd.desc_step = 1'b1;
      end
      S_RESULT: begin
        cmd.sel      = SEL_OLD;
        cmd.load_out = !stat.out_busy;
      end
      S_DEC: begin
        cmd.sel    = SEL_OLD;
        cmd.dec_wr = 1'b1;
      end
      default: cmd.sel = SEL_LIVE;
    endcase
  end

endmodule

@@ rtl/core/swrs_dp.sv @@
module swrs_dp (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  swrs_pkg::cfg_idx_t cfg_index,
  input  swrs_pkg::cfg_t     cfg_data,
  input  swrs_pkg::sample_t  sample,
  output swrs_pkg::sample_t  beauty,
  output logic               out_valid,
  input  logic               out_ready,
  input  swrs_pkg::cmd_t     cmd,
  output swrs_pkg::stat_t    stat
);
  import swrs_pkg::*;

  cfg_t    window_length;
  cfg_t    rank;
  cnt_t    fill;
  ptr_t    ptr;
  bin_t    bin_q;
  sample_t ring_q;
  bin_t    path;
  bin_t    path_next;
  cnt_t    want;
  cnt_t    len_eff;
  cfg_t    rank_eff;
  bin_t    sel_bin;
  ptr_t    oldest;
  cnt_t    left;
  logic    go_right;
  lidx_t   bitpos;
  logic    lvl_wr;
  cnt_t    rd_lvl [BIN_W];
  sample_t ring [MAX_WINDOW];

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= CFG_RESET;
      rank          <= CFG_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_WINDOW_LENGTH) begin
        window_length <= cfg_data;
      end else if (cfg_index == REG_RANK) begin
        rank <= cfg_data;
      end
    end
  end

  always_comb begin
    if (window_length == '0) begin
      len_eff = cnt_t'(1);
    end else if (32'(window_length) > MAX_WINDOW) begin
      len_eff = cnt_t'(MAX_WINDOW);
    end else begin
      len_eff = cnt_t'(window_length);
    end
    rank_eff = (rank == '0) ? cfg_t'(1) : rank;
  end

  assign stat.emit     = fill >= len_eff;
  assign stat.hit      = 32'(rank_eff) <= 32'(fill);
  assign stat.out_busy = out_valid && !out_ready;

  // fill count and ring pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      ptr  <= '0;
    end else if (cmd.accept) begin
      ptr <= ptr + ptr_t'(1);
      if (fill != cnt_t'(MAX_WINDOW)) fill <= fill + cnt_t'(1);
    end else if (cmd.dec_wr) begin
      fill <= fill - cnt_t'(1);
    end
  end

  assign oldest = ptr - ptr_t'(fill);

  // sample ring
  always_ff @(posedge clk) begin
    if (cmd.accept) ring[ptr] <= sample;
    if (cmd.ring_rd) ring_q <= ring[oldest];
    if (cmd.accept) bin_q <= bin_of(sample);
  end

  // descent through the count tree, one level per cycle
  assign left     = rd_lvl[cmd.lvl];
  assign go_right = want > left;
  assign bitpos   = LAST_LVL - cmd.lvl;

  always_comb begin
    path_next = path;
    if (cmd.desc_step && go_right) path_next[bitpos] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.desc_init) begin
      path <= '0;
      want <= cnt_t'(rank_eff);
    end else if (cmd.desc_step) begin
      path <= path_next;
      if (go_right) want <= want - left;
    end
  end

  always_comb begin
    unique case (cmd.sel)
      SEL_LIVE: sel_bin = bin_of(sample);
      SEL_NEW:  sel_bin = bin_q;
      SEL_OLD:  sel_bin = bin_of(ring_q);
      SEL_PATH: sel_bin = path_next;
      default:  sel_bin = bin_q;
    endcase
  end

  assign lvl_wr = cmd.inc_wr || cmd.dec_wr;

  // count tree: level g+1 has 2**(g+1) node sums, the last level is the histogram
  for (genvar g = 0; g < BIN_W; g++) begin : g_lvl
    localparam int L     = g + 1;
    localparam int DEPTH = 2 ** L;

    cnt_t             mem [DEPTH];
    logic [DEPTH-1:0] vld;
    logic [L-1:0]     addr;
    cnt_t             rdata;
    cnt_t             wdata;

    assign addr      = sel_bin[BIN_W-1 -: L];
    assign rd_lvl[g] = rdata;

    always_comb begin
      if (cmd.inc_wr) begin
        wdata = rdata + cnt_t'(1);
      end else if (rdata != '0) begin
        wdata = rdata - cnt_t'(1);
      end else begin
        wdata = rdata;
      end
    end

    always_ff @(posedge clk) begin
      if (lvl_wr) mem[addr] <= wdata;
      rdata <= vld[addr] ? mem[addr] : '0;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld <= '0;
      end else if (lvl_wr) begin
        vld[addr] <= 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) beauty <= stat.hit ? beauty_of(path) : '0;
  end

endmodule

@@ rtl/core/sliding_window_rank_select_top.sv @@
// Sliding-window rank filter. Each input beat carries one signed 7-bit sample;
// the block keeps the last window_length samples (a 256-entry ring) and a
// histogram of them held as a binary count tree of 128 leaf bins. Once the
// window is full, every beat yields one output beat: the rank-th smallest
// sample in the window (rank 1 = minimum) if it is negative, else 0; 0 also
// when rank exceeds the samples held. Register 0 is window_length (0 acts as
// 1, values above 256 act as 256), register 1 is rank (0 acts as 1); both
// reset to 1. The user must write them only while the block is idle; the
// block itself does not enforce this. Shrinking the window takes full
// effect only after reset. Steps per beat: accept and read the tree, write
// the increment, then, once the window is full and rank is within the fill,
// a seven-level descent of the count tree (a priming read, then one level per
// cycle), then load the output register and remove the oldest sample; while
// the window fills only the accept and increment steps run. A finished result
// waits in the output register; the next beat is accepted meanwhile, and only
// the load of the following result waits for it to be taken. The histogram
// clears at reset through per-entry valid bits, so no clearing pass is needed.
`include "sliding_window_rank_select_top_assert.svh"

module sliding_window_rank_select_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  swrs_pkg::cfg_idx_t cfg_index,
  input  swrs_pkg::cfg_t     cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  swrs_pkg::sample_t  sample,
  output logic               out_valid,
  input  logic               out_ready,
  output swrs_pkg::sample_t  beauty
);
  import swrs_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequencer: accept, tree update, descent, result load, oldest removal
  swrs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // ring, count tree, config registers and output register
  swrs_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (sample),
    .beauty    (beauty),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // an accepted beat always moves to the tree update first
  `SWRS_ASSERT_NEXT(a_accept_then_busy, clk, rst, in_valid && in_ready, !in_ready)
  // the oldest sample is removed right after the result load
  `SWRS_ASSERT_IMPL(a_dec_after_load, clk, rst, cmd.dec_wr, $past(cmd.load_out))
  // a result never overwrites one still waiting to be taken
  `SWRS_ASSERT_IMPL(a_load_into_free, clk, rst, cmd.load_out, !out_valid || out_ready)

endmodule

@@ sim/sliding_window_rank_select_top_tb.sv @@
module sliding_window_rank_select_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import swrs_pkg::*;

  // Sender and receiver hold-offs are drawn per beat in 0..IDLE_MAX.
  localparam int IDLE_MAX     = 12;
  // Pause before a register write: a beat that fills the window gives no
  // output beat, yet the block may still be busy with it.
  localparam int SETTLE       = 24;
  // Tail after the last expected beat, to catch extra output beats.
  localparam int DRAIN_CYCLES = 40;
  // Watchdog: cycles in a row with no beat on any port.
  localparam int IDLE_LIMIT   = 2000;
  localparam int CFG_TOP      = (1 << CFG_W) - 1;

  typedef enum logic {ROW_BEAT, ROW_REG} row_kind_t;

  // One row of the directed plan: either a register write or a sample beat.
  // A pinned row carries an expected output typed in by hand; all others are
  // checked against the predictor.
  typedef struct packed {
    row_kind_t kind;
    cfg_idx_t  idx;
    cfg_t      data;
    sample_t   smp;
    logic      pinned;
    sample_t   want;
  } plan_row_t;

  typedef struct packed {
    logic    on;
    sample_t val;
  } pin_t;

  localparam int PLAN_LEN = 24;
  localparam plan_row_t PLAN [PLAN_LEN] = '{
    // reset values: window of one, rank one, so each beat returns min(x, 0)
    '{ROW_BEAT, REG_WINDOW_LENGTH, cfg_t'(0), sample_t'(-64), 1'b1, sample_t'(-64)},
    '{ROW_BEAT, REG_WINDOW_LENGTH, cfg_t'(0), sample_t'(63),  1'b1, sample_t'(0)},
    '{ROW_BEAT, REG_WINDOW_LENGTH, cfg_t'(0), sample_t'(-1),  1'b1, sample_t'(-1)},
    '{ROW_BEAT, REG_WINDOW_LENGTH, cfg_t'(0), sample_t'(0),   1'b1, sample_t'(0)},
    '{ROW_BEAT, REG_WINDOW_LENGTH, cfg_t'(0), sample_t'(1),   1'b1, sample_t'(0)},
    // zero window and zero rank both act as one
    '{ROW_REG,  REG_WINDOW_LENGTH, cfg_t'(0), sample_t'(0),   1'b0, sample_t'(0)},
    '{ROW_REG,  REG_RANK,          cfg_t'(0), sample_t'(0),   1'b0, sample_t'(0)},
    '{ROW_BEAT, REG_WINDOW_LENGTH, cfg_t'(0), sample_t'(-33), 1'b1, sample_t'(-33)},
    '{ROW_BEAT, REG_WINDOW_LENGTH, cfg_t'(0), sample_t'(42),  1'b1, sample_t'(0)},
    // grow to a window of three, pick the median
    '{ROW_REG,  REG_WINDOW_LENGTH, cfg_t'(3), sample_t'(0),   1'b0, sample_t'(0)},
    '{ROW_REG,  REG_RANK,          cfg_t'(2), sample_t'(0),   1'b0, sample_t'(0)},
    '{ROW_BEAT, REG_WINDOW_LENGTH, cfg_t'(0), sample_t'(-10), 1'b0, sample_t'(0)},
    '{ROW_BEAT, REG_WINDOW_LENGTH, cfg_t'(0), sample_t'(-20), 1'b0, sample_t'(0)},
    '{ROW_BEAT, REG_WINDOW_LENGTH, cfg_t'(0), sample_t'(-5),  1'b0, sample_t'(0)},
    '{ROW_BEAT, REG_WINDOW_LENGTH, cfg_t'(0), sample_t'(40),  1'b0, sample_t'(0)},
    '{ROW_BEAT, REG_WINDOW_LENGTH, cfg_t'(0), sample_t'(-64), 1'b0, sample_t'(0)},
    // rank past the fill count reads as zero
    '{ROW_REG,  REG_RANK,          cfg_t'(CFG_TOP), sample_t'(0), 1'b0, sample_t'(0)},
    '{ROW_BEAT, REG_WINDOW_LENGTH, cfg_t'(0), sample_t'(-40), 1'b1, sample_t'(0)},
    '{ROW_BEAT, REG_WINDOW_LENGTH, cfg_t'(0), sample_t'(-64), 1'b1, sample_t'(0)},
    '{ROW_REG,  REG_RANK,          cfg_t'(3), sample_t'(0),   1'b0, sample_t'(0)},
    '{ROW_BEAT, REG_WINDOW_LENGTH, cfg_t'(0), sample_t'(-2),  1'b0, sample_t'(0)},
    // shrink: the window keeps its three samples until a reset
    '{ROW_REG,  REG_WINDOW_LENGTH, cfg_t'(1), sample_t'(0),   1'b0, sample_t'(0)},
    '{ROW_BEAT, REG_WINDOW_LENGTH, cfg_t'(0), sample_t'(-50), 1'b0, sample_t'(0)},
    '{ROW_BEAT, REG_WINDOW_LENGTH, cfg_t'(0), sample_t'(10),  1'b0, sample_t'(0)}
  };

  logic     clk;
  logic     rst       = 1'b1;
  logic     cfg_we    = 1'b0;
  cfg_idx_t cfg_index = REG_WINDOW_LENGTH;
  cfg_t     cfg_data  = '0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  sample_t  sample    = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  sample_t  beauty;

  // Predictor state: histogram, sample ring, fill level, write pointer.
  int unsigned hist [NUM_BINS] = '{default: 0};
  sample_t     ring [MAX_WINDOW];
  int          fill     = 0;
  ptr_t        head     = '0;
  cfg_t        win_len  = CFG_RESET;
  cfg_t        rank_sel = CFG_RESET;

  sample_t beauty_due [$];   // expected output beats, oldest first
  pin_t    pinned_q [$];     // one entry per sample beat still to be taken
  int      beats_owed = 0;   // registered copy of beauty_due.size()
  int      mismatches = 0;
  int      idle_run   = 0;
  bit      tx_calm    = 1'b0;
  bit      rx_calm    = 1'b0;

  sliding_window_rank_select_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .sample    (sample),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .beauty    (beauty)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic note_mismatch(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // Adds one sample to the window; returns 1 when the window is full and an
  // output beat is due, with its value in pick. The oldest sample leaves after.
  function automatic bit rank_filter_step(input sample_t s, output sample_t pick);
    int len;
    int want;
    int acc;
    int slot;
    int v;
    int b;
    ptr_t oldest;
    len = (win_len == 0) ? 1 : ((win_len > MAX_WINDOW) ? MAX_WINDOW : int'(win_len));
    // a 7-bit sample plus the offset always lands inside the histogram
    b = int'(s) + VALUE_OFFSET;
    hist[b]++;
    ring[head] = s;
    head = head + ptr_t'(1);
    if (fill < MAX_WINDOW) fill++;
    pick = '0;
    if (fill < len) return 1'b0;
    want = (rank_sel == 0) ? 1 : int'(rank_sel);
    if (want <= fill) begin
      acc = 0;
      slot = NUM_BINS;
      for (int i = 0; i < NUM_BINS; i++) begin
        acc += hist[i];
        if (slot == NUM_BINS && acc >= want) slot = i;
      end
      if (slot < NUM_BINS) begin
        v = slot - VALUE_OFFSET;
        if (v < SAMPLE_MIN) v = SAMPLE_MIN;
        if (v < 0) pick = sample_t'(v);
      end
    end
    oldest = ptr_t'(int'(head) + MAX_WINDOW - fill);
    b = int'(ring[oldest]) + VALUE_OFFSET;
    if (hist[b] > 0) hist[b]--;
    fill--;
    return 1'b1;
  endfunction

  // Mostly uniform, with the field extremes and a narrow cluster around zero
  // so that the histogram sees many repeated values.
  function automatic sample_t draw_sample();
    case ($urandom_range(9, 0))
      0: begin
        case ($urandom_range(3, 0))
          0: return sample_t'(SAMPLE_MIN);
          1: return sample_t'(-SAMPLE_MIN - 1);
          2: return sample_t'(-1);
          default: return sample_t'(0);
        endcase
      end
      1, 2: return sample_t'(int'($urandom_range(7, 0)) - 4);
      default: return sample_t'($urandom_range(127, 0));
    endcase
  endfunction

  // Drives one sample beat after a random hold-off; returns in the time step
  // of the accepting edge with in_valid still high.
  task automatic send_sample(input sample_t s, input bit pinned, input sample_t want);
    int unsigned gap;
    pin_t        entry;
    gap = tx_calm ? 0 : $urandom_range(IDLE_MAX, 0);
    if ($urandom_range(39, 0) == 0) tx_calm = !tx_calm;
    entry.on  = pinned;
    entry.val = want;
    pinned_q.insert(pinned_q.size(), entry);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample   <= s;
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  // Register write once the block has gone quiet: all output beats taken,
  // then a settle pause for a fill-only beat still in flight.
  task automatic write_reg(input cfg_idx_t idx, input cfg_t data);
    in_valid <= 1'b0;
    do @(posedge clk); while (beats_owed != 0);
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Receiver: random stall per output beat, with calm stretches of none.
  initial begin : sink
    int unsigned stall;
    forever begin
      stall = rx_calm ? 0 : $urandom_range(IDLE_MAX, 0);
      if ($urandom_range(39, 0) == 0) rx_calm = !rx_calm;
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // Scoreboard: everything is sampled at the clock edge, so it sees the
  // values that the block itself sees when a beat is taken.
  always @(posedge clk) begin : scoreboard
    pin_t    pin;
    sample_t pick;
    logic    made;
    logic    moved;
    if (!rst) begin
      moved = cfg_we;
      if (cfg_we) begin
        if (cfg_index == REG_WINDOW_LENGTH) begin
          win_len = cfg_data;
        end else if (cfg_index == REG_RANK) begin
          rank_sel = cfg_data;
        end
      end
      if (in_valid && in_ready) begin
        moved = 1'b1;
        pin   = pinned_q.pop_front();
        made  = rank_filter_step(sample, pick);
        if (pin.on) begin
          beauty_due.insert(beauty_due.size(), pin.val);
        end else if (made) begin
          beauty_due.insert(beauty_due.size(), pick);
        end
      end
      if (out_valid && out_ready) begin
        moved = 1'b1;
        if (beauty_due.size() == 0) begin
          note_mismatch($sformatf("output beat %0d with none expected", beauty));
        end else begin
          pick = beauty_due.pop_front();
          if (beauty !== pick) begin
            note_mismatch($sformatf("beauty %0d, expected %0d", beauty, pick));
          end
        end
      end
      idle_run = moved ? 0 : idle_run + 1;
      if (idle_run >= IDLE_LIMIT) begin
        $display("%0t watchdog: no beat for %0d cycles", $time, IDLE_LIMIT);
        $display("** sliding_window_rank_select_top: FAILED **");
        $finish;
      end
      beats_owed <= beauty_due.size();
    end
  end

  initial begin : stimulus
    int unsigned win;
    int unsigned eff;
    int unsigned rk;
    int unsigned count;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed plan
    for (int r = 0; r < PLAN_LEN; r++) begin
      if (PLAN[r].kind == ROW_REG) begin
        write_reg(PLAN[r].idx, PLAN[r].data);
      end else begin
        send_sample(PLAN[r].smp, PLAN[r].pinned, PLAN[r].want);
      end
    end

    // Random phases. Small windows first; the full 256-deep window comes
    // last since, without a reset, the window never shrinks again.
    for (int p = 0; p < 10; p++) begin
      if (p < 8) begin
        case ($urandom_range(5, 0))
          0: win = 0;
          1: win = 1;
          2: win = 2;
          5: win = $urandom_range(96, 21);
          default: win = $urandom_range(20, 3);
        endcase
        eff = (win == 0) ? 1 : win;
        case ($urandom_range(5, 0))
          0: rk = 0;
          1: rk = 1;
          2: rk = eff;
          5: rk = $urandom_range(CFG_TOP, eff + 1);
          default: rk = $urandom_range(eff, 1);
        endcase
        count = $urandom_range(200, 120);
      end else if (p == 8) begin
        win   = MAX_WINDOW;
        rk    = $urandom_range(MAX_WINDOW, 1);
        count = 320;
      end else begin
        // above the ring depth: acts as the full ring
        win   = $urandom_range(CFG_TOP, MAX_WINDOW + 1);
        rk    = MAX_WINDOW;
        count = 200;
      end
      write_reg(REG_WINDOW_LENGTH, cfg_t'(win));
      write_reg(REG_RANK, cfg_t'(rk));
      repeat (count) send_sample(draw_sample(), 1'b0, '0);
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (beats_owed != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("** sliding_window_rank_select_top: PASSED **");
    end else begin
      $display("** sliding_window_rank_select_top: FAILED **");
    end
    $finish;
  end

endmodule
